### src/dm64_pkg.sv
// Shared mode codes and the per-item control word of the pipelined divider.
package dm64_pkg;

    // Operation codes carried on the mode field.
    localparam logic [1:0] MODE_UQUO = 2'd0;
    localparam logic [1:0] MODE_UREM = 2'd1;
    localparam logic [1:0] MODE_SQUO = 2'd2;
    localparam logic [1:0] MODE_SREM = 2'd3;

    // Control flags that travel with each item down the pipeline.
    typedef struct packed {
        logic rem_sel;   // deliver the remainder instead of the quotient
        logic neg_quo;   // operand signs differ in a signed mode
        logic neg_rem;   // dividend was negative in a signed mode
        logic dvs_zero;  // divisor is zero, the result is forced to zero
    } dm64_ctl_t;

endpackage

### src/dm64_prep.sv
// Input stage: decodes the mode and registers operand magnitudes and sign flags.
module dm64_prep #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid_in,
    input  logic [1:0]              mode,
    input  logic [DATA_WIDTH-1:0]   dividend,
    input  logic [DATA_WIDTH-1:0]   divisor,
    output logic                    valid_out,
    output logic [DATA_WIDTH-1:0]   rem_out,
    output logic [DATA_WIDTH-1:0]   nq_out,
    output logic [DATA_WIDTH-1:0]   dvs_out,
    output dm64_pkg::dm64_ctl_t     ctl_out
);

    localparam logic [DATA_WIDTH-1:0] ZERO = '0;

    logic                  is_signed;
    logic                  n_neg;
    logic                  d_neg;
    logic [DATA_WIDTH-1:0] n_mag;
    logic [DATA_WIDTH-1:0] d_mag;
    dm64_pkg::dm64_ctl_t   ctl_next;

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] nq_reg;
    logic [DATA_WIDTH-1:0] dvs_reg;
    dm64_pkg::dm64_ctl_t   ctl_reg;

    // Sign decode and magnitude conversion for the signed modes.
    always_comb
    begin
        is_signed = (mode == dm64_pkg::MODE_SQUO) || (mode == dm64_pkg::MODE_SREM);
        n_neg     = is_signed && dividend[DATA_WIDTH-1];
        d_neg     = is_signed && divisor[DATA_WIDTH-1];
        n_mag     = n_neg ? (ZERO - dividend) : dividend;
        d_mag     = d_neg ? (ZERO - divisor) : divisor;
        ctl_next.rem_sel  = (mode == dm64_pkg::MODE_UREM) || (mode == dm64_pkg::MODE_SREM);
        ctl_next.neg_quo  = n_neg ^ d_neg;
        ctl_next.neg_rem  = n_neg;
        ctl_next.dvs_zero = (divisor == ZERO);
    end

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload of the stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq_reg  <= n_mag;
            dvs_reg <= d_mag;
            ctl_reg <= ctl_next;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = ZERO;
    assign nq_out    = nq_reg;
    assign dvs_out   = dvs_reg;
    assign ctl_out   = ctl_reg;

endmodule

### src/dm64_step.sv
// One restoring shift-subtract step of the divider, registered.
module dm64_step #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid_in,
    input  logic [DATA_WIDTH-1:0]   rem_in,
    input  logic [DATA_WIDTH-1:0]   nq_in,
    input  logic [DATA_WIDTH-1:0]   dvs_in,
    input  dm64_pkg::dm64_ctl_t     ctl_in,
    output logic                    valid_out,
    output logic [DATA_WIDTH-1:0]   rem_out,
    output logic [DATA_WIDTH-1:0]   nq_out,
    output logic [DATA_WIDTH-1:0]   dvs_out,
    output dm64_pkg::dm64_ctl_t     ctl_out
);

    logic [DATA_WIDTH:0]   rem_shift;
    logic [DATA_WIDTH:0]   diff;
    logic                  borrow;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] nq_next;

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] nq_reg;
    logic [DATA_WIDTH-1:0] dvs_reg;
    dm64_pkg::dm64_ctl_t   ctl_reg;

    // Shift in the next dividend bit and try to subtract the divisor.
    // The low end of nq collects quotient bits as the dividend shifts out.
    always_comb
    begin
        rem_shift = {rem_in, nq_in[DATA_WIDTH-1]};
        diff      = rem_shift - {1'b0, dvs_in};
        borrow    = diff[DATA_WIDTH];
        rem_next  = borrow ? rem_shift[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
        nq_next   = {nq_in[DATA_WIDTH-2:0], ~borrow};
    end

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload of the stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
            dvs_reg <= dvs_in;
            ctl_reg <= ctl_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign nq_out    = nq_reg;
    assign dvs_out   = dvs_reg;
    assign ctl_out   = ctl_reg;

endmodule

### src/dm64_post.sv
// Output stage: selects quotient or remainder, fixes the sign and holds the result.
module dm64_post #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid_in,
    input  logic [DATA_WIDTH-1:0]   rem_in,
    input  logic [DATA_WIDTH-1:0]   quo_in,
    input  dm64_pkg::dm64_ctl_t     ctl_in,
    output logic                    valid_out,
    output logic [DATA_WIDTH-1:0]   result
);

    localparam logic [DATA_WIDTH-1:0] ZERO = '0;

    logic [DATA_WIDTH-1:0] sel;
    logic                  neg;
    logic [DATA_WIDTH-1:0] result_next;

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] result_reg;

    // Pick the requested value and restore its sign; a zero divisor gives zero.
    always_comb
    begin
        sel = ctl_in.rem_sel ? rem_in : quo_in;
        neg = ctl_in.rem_sel ? ctl_in.neg_rem : ctl_in.neg_quo;
        if (ctl_in.dvs_zero)
        begin
            result_next = ZERO;
        end
        else if (neg)
        begin
            result_next = ZERO - sel;
        end
        else
        begin
            result_next = sel;
        end
    end

    // Valid bit of the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign valid_out = valid_reg;
    assign result    = result_reg;

endmodule

### src/divmod64_signed_unsigned.sv
// Top level of the pipelined signed and unsigned divider.
//
// Input channel: in_valid, in_stall, mode, dividend, divisor. Output channel:
// out_valid, out_stall, result. An item moves at a clock edge where valid is
// high and stall is low.
// Modes: unsigned quotient, unsigned remainder, signed quotient, signed
// remainder. A zero divisor gives zero; the most negative value over minus
// one wraps to the most negative value.
// The pipeline has one input stage for sign handling, one register stage per
// quotient bit and one output stage for sign restore.
// Throughput is one item per cycle unless the output stalls; each step stage
// does one restoring subtract. When the receiver stalls with a result waiting,
// the whole pipeline holds and in_stall goes high; otherwise items keep moving
// even while the output register is being refilled.
// Reset clears all valid bits at once; the block accepts items in the first
// cycle after reset is released.
module divmod64_signed_unsigned #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            mode,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_WIDTH-1:0] result
);

    logic                  advance;
    logic                  v_s   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_s [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] nq_s  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] dvs_s [0:DATA_WIDTH];
    dm64_pkg::dm64_ctl_t   ctl_s [0:DATA_WIDTH];

    // The pipeline moves unless a result waits at a stalled output.
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    // Sign handling and operand registers.
    dm64_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .valid_in  (in_valid),
        .mode      (mode),
        .dividend  (dividend),
        .divisor   (divisor),
        .valid_out (v_s[0]),
        .rem_out   (rem_s[0]),
        .nq_out    (nq_s[0]),
        .dvs_out   (dvs_s[0]),
        .ctl_out   (ctl_s[0])
    );

    // One register stage per quotient bit.
    for (genvar k = 0; k < DATA_WIDTH; k++)
    begin : g_step
        dm64_step #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .valid_in  (v_s[k]),
            .rem_in    (rem_s[k]),
            .nq_in     (nq_s[k]),
            .dvs_in    (dvs_s[k]),
            .ctl_in    (ctl_s[k]),
            .valid_out (v_s[k+1]),
            .rem_out   (rem_s[k+1]),
            .nq_out    (nq_s[k+1]),
            .dvs_out   (dvs_s[k+1]),
            .ctl_out   (ctl_s[k+1])
        );
    end

    // Result selection, sign restore and output register.
    dm64_post #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .valid_in  (v_s[DATA_WIDTH]),
        .rem_in    (rem_s[DATA_WIDTH]),
        .quo_in    (nq_s[DATA_WIDTH]),
        .ctl_in    (ctl_s[DATA_WIDTH]),
        .valid_out (out_valid),
        .result    (result)
    );

    // The divisor is only consumed by the steps; the last copy is unused.
    logic unused_dvs;
    assign unused_dvs = ^dvs_s[DATA_WIDTH];

endmodule

### src/dm64_checker.sv
// Port-level checker for the divider and the bind that attaches it.
module dm64_checker #(
    parameter int DATA_WIDTH = 64
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [DATA_WIDTH-1:0] result
);

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result))
        else $error("stalled result changed or dropped");

    // The input side only stalls when a result waits at a stalled output.
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // A result leaves only after it was taken.
    a_out_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result dropped without being taken");

    // With the output free, the input is never stalled.
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output is empty");

    logic unused_in_valid;
    assign unused_in_valid = in_valid;

endmodule

bind divmod64_signed_unsigned dm64_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_dm64_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
);

### tb/divmod64_checker.sv
// Result checker for the divider: predicts each accepted division and compares the results.
module divmod64_checker #(
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [1:0]       mode,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic [WIDTH-1:0] result,
    output int               fail_count,
    output int               pending
);

    // One accepted division together with the result it must produce.
    typedef struct {
        logic [1:0]       mode;
        logic [WIDTH-1:0] dividend;
        logic [WIDTH-1:0] divisor;
        logic [WIDTH-1:0] answer;
    } division_t;

    division_t expected_results[$];
    int        errors = 0;
    int        outstanding = 0;

    assign fail_count = errors;
    assign pending    = outstanding;

    // Plain restoring shift-subtract division of two unsigned magnitudes.
    function automatic void restoring_divide(input logic [WIDTH-1:0] num,
                                             input logic [WIDTH-1:0] den,
                                             output logic [WIDTH-1:0] quo,
                                             output logic [WIDTH-1:0] rem);
        logic [WIDTH:0] partial;
        partial = '0;
        quo     = '0;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            partial = {partial[WIDTH-1:0], num[i]};
            quo     = {quo[WIDTH-2:0], 1'b0};
            if (partial >= {1'b0, den})
            begin
                partial = partial - {1'b0, den};
                quo[0]  = 1'b1;
            end
        end
        rem = partial[WIDTH-1:0];
    endfunction

    // Quotient or remainder as the mode selects; signed modes divide magnitudes.
    function automatic logic [WIDTH-1:0] divmod_expected(input logic [1:0] op,
                                                         input logic [WIDTH-1:0] num,
                                                         input logic [WIDTH-1:0] den);
        logic             is_signed;
        logic             num_neg;
        logic             den_neg;
        logic [WIDTH-1:0] mag_num;
        logic [WIDTH-1:0] mag_den;
        logic [WIDTH-1:0] quo;
        logic [WIDTH-1:0] rem;
        is_signed = (op == dm64_pkg::MODE_SQUO) || (op == dm64_pkg::MODE_SREM);
        num_neg   = is_signed && num[WIDTH-1];
        den_neg   = is_signed && den[WIDTH-1];
        mag_num   = num_neg ? -num : num;
        mag_den   = den_neg ? -den : den;
        if (den == '0)
            return '0;
        restoring_divide(mag_num, mag_den, quo, rem);
        case (op)
            dm64_pkg::MODE_UQUO, dm64_pkg::MODE_SQUO:
                return (num_neg != den_neg) ? -quo : quo;
            default:
                return num_neg ? -rem : rem;
        endcase
    endfunction

    // Record every accepted item and match every accepted result against the oldest one.
    always @(posedge clk or negedge rst_n)
    begin
        division_t item;
        if (!rst_n)
        begin
            expected_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                item.mode     = mode;
                item.dividend = dividend;
                item.divisor  = divisor;
                item.answer   = divmod_expected(mode, dividend, divisor);
                expected_results.push_back(item);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result %h arrived with no division outstanding, expected none",
                             $time, result);
                end
                else
                begin
                    item = expected_results.pop_front();
                    if (result !== item.answer)
                    begin
                        errors++;
                        $display("%0t: mode %0d, %h / %h: expected %h, actual %h", $time,
                                 item.mode, item.dividend, item.divisor, item.answer, result);
                    end
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

### tb/tb_divmod64_signed_unsigned.sv
// Testbench top for the divider: clock, reset, item stimulus, receiver stalls and the verdict.
module tb_divmod64_signed_unsigned;

    localparam int WIDTH       = 64;
    localparam int LATENCY     = WIDTH + 2;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] MOST_POS = {1'b0, {(WIDTH-1){1'b1}}};
    localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [1:0]       mode;
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;
    logic             out_valid;
    logic             out_stall;
    logic [WIDTH-1:0] result;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int quiet_cycles  = 0;

    // Operand pairs for the directed part, run in every mode.
    logic [WIDTH-1:0] corner_dividend [6] = '{MOST_NEG, 64'h0123_4567_89ab_cdef, ALL_ONES,
                                              '0, MOST_POS, 64'hffff_ffff_ffff_fff9};
    logic [WIDTH-1:0] corner_divisor  [6] = '{ALL_ONES, '0, 64'd1,
                                              ALL_ONES, MOST_NEG, 64'd2};

    divmod64_signed_unsigned #(
        .DATA_WIDTH(WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .dividend (dividend),
        .divisor  (divisor),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result   (result)
    );

    divmod64_checker #(
        .WIDTH(WIDTH)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .dividend  (dividend),
        .divisor   (divisor),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        out_stall   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_requests > hold_served)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Operand with a bias toward special values and short magnitudes of either sign.
    function automatic logic [WIDTH-1:0] pick_operand();
        logic [WIDTH-1:0] raw;
        int               span;
        raw  = {$urandom, $urandom};
        span = $urandom_range(WIDTH, 1);
        case ($urandom_range(11))
            0:       return '0;
            1:       return 64'd1;
            2:       return ALL_ONES;
            3:       return MOST_NEG;
            4:       return MOST_POS;
            5, 6:    return raw >> (WIDTH - span);
            7, 8:    return -(raw >> (WIDTH - span));
            default: return raw;
        endcase
    endfunction

    // Offer one item after an optional idle gap and hold it until accepted.
    task automatic send_division(input logic [1:0] op, input logic [WIDTH-1:0] num,
                                 input logic [WIDTH-1:0] den);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        dividend <= num;
        divisor  <= den;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_division(2'($urandom_range(3)), pick_operand(), pick_operand());
    endtask

    // Stop offering items and wait until every outstanding result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        mode     = dm64_pkg::MODE_UQUO;
        dividend = '0;
        divisor  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Sender mostly busy, receiver mostly stalled; corner cases in every mode first.
        send_idle_pct = 20;
        recv_idle_pct = 86;
        for (int m = 0; m < 4; m++)
            for (int k = 0; k < 6; k++)
                send_division(2'(m), corner_dividend[k], corner_divisor[k]);
        send_random(430);
        wait_drained();

        // Sender mostly idle, receiver mostly ready.
        send_idle_pct = 86;
        recv_idle_pct = 20;
        send_random(430);
        wait_drained();

        // Full rate, then a long receiver hold-off while items keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(300);
        hold_requests = hold_requests + 1;
        send_random(150);
        wait_drained();
        send_random(70);
        wait_drained();

        repeat (LATENCY + 8) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
src/dm64_pkg.sv
src/dm64_prep.sv
src/dm64_step.sv
src/dm64_post.sv
src/divmod64_signed_unsigned.sv
src/dm64_checker.sv
tb/divmod64_checker.sv
tb/tb_divmod64_signed_unsigned.sv
